FILE: src/pdr_pkg.sv
package pdr_pkg;

  localparam int unsigned LEN_BITS       = 24;
  localparam int unsigned MAX_CFG_BITS   = 27;

  // A packet of this length keeps the message open.
  localparam logic [LEN_BITS-1:0]     FULL_PACKET_LEN = 24'hFF_FFFF;
  localparam logic [MAX_CFG_BITS-1:0] MAX_RESET       = 27'd67108864;

  // Header byte positions.
  localparam logic [1:0] HDR_LEN_LO  = 2'd0;
  localparam logic [1:0] HDR_LEN_MID = 2'd1;
  localparam logic [1:0] HDR_LEN_HI  = 2'd2;
  localparam logic [1:0] HDR_SEQ     = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       end_of_message;
    logic [7:0] pkt_seq;
    logic       overflow_error;
  } pdr_result_t;

endpackage

FILE: src/pdr_in_if.sv
interface pdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/pdr_out_if.sv
interface pdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       end_of_message;
  logic [7:0] pkt_seq;
  logic       overflow_error;

  modport source (
    output valid, output payload_byte, output has_byte, output end_of_message,
    output pkt_seq, output overflow_error, input ready
  );
  modport sink (
    input valid, input payload_byte, input has_byte, input end_of_message,
    input pkt_seq, input overflow_error, output ready
  );
endinterface

FILE: src/packet_deframer_reassembler.sv
// Length-prefixed packet reassembler. Each packet on the byte stream starts
// with a 24-bit little-endian length and a sequence byte; every payload byte
// comes out as one result item, and a packet of length 0xFFFFFF continues the
// message while a shorter one ends it with end_of_message. The block accepts
// one byte per cycle while the result side takes items: the byte is first held in
// an input register, then the header and counter update
// writes the result register. Length bytes make no result; the sequence byte
// makes one only for an empty packet or an overflow. If the running total would pass cfg_wdata's limit, one
// overflow item is sent and all later bytes are dropped until reset.
module packet_deframer_reassembler #(
  parameter int unsigned TOTAL_COUNT_BITS = 27
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pdr_in_if.sink                           in_ch,
  pdr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pdr_pkg::MAX_CFG_BITS-1:0] cfg_wdata
);
  import pdr_pkg::*;

  logic                    stg_valid_r, stg_valid_nxt;
  logic [7:0]              stg_byte_r;
  logic                    out_valid_r, out_valid_nxt;
  pdr_result_t             out_res_r;
  logic [MAX_CFG_BITS-1:0] max_r;

  logic        stg_adv;
  logic        in_fire;
  logic        core_valid;
  pdr_result_t core_res;

  assign stg_adv     = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || stg_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  pdr_core #(
    .TOTAL_COUNT_BITS(TOTAL_COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (stg_adv),
    .rx_byte  (stg_byte_r),
    .max_bytes(max_r),
    .res_valid(core_valid),
    .res      (core_res)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (stg_adv) begin
      out_valid_nxt = core_valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= MAX_RESET;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_ch.rx_byte;
    end
    if (stg_adv && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_byte   = out_res_r.payload_byte;
  assign out_ch.has_byte       = out_res_r.has_byte;
  assign out_ch.end_of_message = out_res_r.end_of_message;
  assign out_ch.pkt_seq        = out_res_r.pkt_seq;
  assign out_ch.overflow_error = out_res_r.overflow_error;

  // A waiting result must never be overwritten by the next byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !stg_adv)
    else $error("stage advanced over a stalled result");

  // After the overflow item leaves, nothing else is ever produced.
  a_silent_after_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.ready && out_res_r.overflow_error |=> !out_valid_r)
    else $error("result produced after overflow");

  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.overflow_error &&
                      (out_res_r.has_byte || out_res_r.end_of_message)))
    else $error("overflow item carries data or end of message");

endmodule

FILE: src/pdr_core.sv
module pdr_core #(
  parameter int unsigned TOTAL_COUNT_BITS = 27
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    rx_byte,
  input  logic [pdr_pkg::MAX_CFG_BITS-1:0] max_bytes,
  output logic                          res_valid,
  output pdr_pkg::pdr_result_t          res
);
  import pdr_pkg::*;

  localparam int unsigned SUM_W =
    ((TOTAL_COUNT_BITS > LEN_BITS) ? TOTAL_COUNT_BITS : LEN_BITS) + 1;
  localparam int unsigned CMP_W = (SUM_W > MAX_CFG_BITS) ? SUM_W : MAX_CFG_BITS;
  localparam logic [CMP_W-1:0] TOTAL_CAP = (CMP_W'(1) << TOTAL_COUNT_BITS) - CMP_W'(1);

  logic                        in_payload_r, in_payload_nxt;
  logic [1:0]                  hdr_idx_r, hdr_idx_nxt;
  logic [LEN_BITS-1:0]         len_r, len_nxt;
  logic [LEN_BITS-1:0]         left_r, left_nxt;
  logic                        full_r, full_nxt;
  logic [7:0]                  seq_r, seq_nxt;
  logic [TOTAL_COUNT_BITS-1:0] total_r, total_nxt;
  logic                        halted_r, halted_nxt;

  logic [LEN_BITS-1:0] left_dec;
  logic [CMP_W-1:0]    sum;
  logic [CMP_W-1:0]    max_ext;
  logic [CMP_W-1:0]    limit;

  assign left_dec = left_r - LEN_BITS'(1);
  assign sum      = CMP_W'(total_r) + CMP_W'(len_r);
  assign max_ext  = CMP_W'(max_bytes);
  // The total register can never wrap: the limit saturates at its capacity.
  assign limit    = (max_ext > TOTAL_CAP) ? TOTAL_CAP : max_ext;

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    len_nxt        = len_r;
    left_nxt       = left_r;
    full_nxt       = full_r;
    seq_nxt        = seq_r;
    total_nxt      = total_r;
    halted_nxt     = halted_r;
    res_valid      = 1'b0;
    res            = '0;
    res.pkt_seq    = seq_r;

    if (step && !halted_r) begin
      if (in_payload_r) begin
        left_nxt           = left_dec;
        res_valid          = 1'b1;
        res.payload_byte   = rx_byte;
        res.has_byte       = 1'b1;
        res.end_of_message = (left_dec == '0) && !full_r;
        if (left_dec == '0) begin
          in_payload_nxt = 1'b0;
          hdr_idx_nxt    = HDR_LEN_LO;
          len_nxt        = '0;
          if (!full_r) begin
            total_nxt = '0;
          end
        end
      end else begin
        unique case (hdr_idx_r)
          HDR_LEN_LO: begin
            len_nxt[7:0] = rx_byte;
            hdr_idx_nxt  = HDR_LEN_MID;
          end
          HDR_LEN_MID: begin
            len_nxt[15:8] = rx_byte;
            hdr_idx_nxt   = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            len_nxt[23:16] = rx_byte;
            hdr_idx_nxt    = HDR_SEQ;
          end
          HDR_SEQ: begin
            seq_nxt         = rx_byte;
            hdr_idx_nxt     = HDR_LEN_LO;
            len_nxt         = '0;
            full_nxt        = (len_r == FULL_PACKET_LEN);
            res.pkt_seq     = rx_byte;
            if (len_r == '0) begin
              res_valid          = 1'b1;
              res.end_of_message = 1'b1;
              total_nxt          = '0;
            end else if (sum > limit) begin
              res_valid          = 1'b1;
              res.overflow_error = 1'b1;
              halted_nxt         = 1'b1;
            end else begin
              total_nxt      = sum[TOTAL_COUNT_BITS-1:0];
              left_nxt       = len_r;
              in_payload_nxt = 1'b1;
            end
          end
          default: begin
            hdr_idx_nxt = HDR_LEN_LO;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_idx_r    <= HDR_LEN_LO;
      len_r        <= '0;
      left_r       <= '0;
      full_r       <= 1'b0;
      seq_r        <= '0;
      total_r      <= '0;
      halted_r     <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      len_r        <= len_nxt;
      left_r       <= left_nxt;
      full_r       <= full_nxt;
      seq_r        <= seq_nxt;
      total_r      <= total_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule

FILE: tb/sv/tb_packet_deframer_reassembler.sv
`timescale 1ns / 100ps

module tb_packet_deframer_reassembler;
  import pdr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 6;

  // Mirrors the deframer state and holds the result items it should send.
  class reassembly_scoreboard;
    logic [MAX_CFG_BITS-1:0] limit;
    bit                      in_payload;
    logic [1:0]              hdr_pos;
    logic [LEN_BITS-1:0]     len_acc;
    logic [LEN_BITS-1:0]     remaining;
    bit                      full_pkt;
    logic [7:0]              seq;
    logic [MAX_CFG_BITS-1:0] msg_total;
    bit                      halted;
    pdr_result_t             pending_results[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             messages_closed;
    int unsigned             overflows;

    function new();
      limit      = MAX_RESET;
      in_payload = 1'b0;
      hdr_pos    = HDR_LEN_LO;
      len_acc    = '0;
      remaining  = '0;
      full_pkt   = 1'b0;
      seq        = '0;
      msg_total  = '0;
      halted     = 1'b0;
    endfunction

    function void note_byte(input logic [7:0] value);
      pdr_result_t         r;
      logic [LEN_BITS-1:0] plen;
      r = '0;
      if (halted) return;
      if (in_payload) begin
        remaining = remaining - 1'b1;
        r.payload_byte   = value;
        r.has_byte       = 1'b1;
        r.end_of_message = (remaining == 0) && !full_pkt;
        r.pkt_seq        = seq;
        pending_results = {pending_results, r};
        if (remaining == 0) begin
          in_payload = 1'b0;
          hdr_pos    = HDR_LEN_LO;
          len_acc    = '0;
          if (!full_pkt) msg_total = '0;
        end
        return;
      end
      if (hdr_pos != HDR_SEQ) begin
        len_acc = len_acc | (LEN_BITS'(value) << (8 * hdr_pos));
        hdr_pos = hdr_pos + 1'b1;
        return;
      end
      seq      = value;
      hdr_pos  = HDR_LEN_LO;
      plen     = len_acc;
      len_acc  = '0;
      full_pkt = (plen == FULL_PACKET_LEN);
      r.pkt_seq = seq;
      if (plen == 0) begin
        r.end_of_message = 1'b1;
        pending_results = {pending_results, r};
        msg_total = '0;
        return;
      end
      // A 27-bit limit always fits the 27-bit total, so no saturation is needed.
      if ({1'b0, msg_total} + (MAX_CFG_BITS + 1)'(plen) > {1'b0, limit}) begin
        r.overflow_error = 1'b1;
        pending_results = {pending_results, r};
        halted = 1'b1;
        return;
      end
      msg_total  = msg_total + MAX_CFG_BITS'(plen);
      remaining  = plen;
      in_payload = 1'b1;
    endfunction

    task report(input string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(input pdr_result_t got);
      pdr_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result item %h arrived with nothing expected", got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.payload_byte !== want.payload_byte)
        report($sformatf("payload_byte %h, expected %h", got.payload_byte, want.payload_byte));
      if (got.has_byte !== want.has_byte)
        report($sformatf("has_byte %b, expected %b", got.has_byte, want.has_byte));
      if (got.end_of_message !== want.end_of_message)
        report($sformatf("end_of_message %b, expected %b", got.end_of_message,
                         want.end_of_message));
      if (got.pkt_seq !== want.pkt_seq)
        report($sformatf("pkt_seq %h, expected %h", got.pkt_seq, want.pkt_seq));
      if (got.overflow_error !== want.overflow_error)
        report($sformatf("overflow_error %b, expected %b", got.overflow_error,
                         want.overflow_error));
      if (want.end_of_message) messages_closed++;
      if (want.overflow_error) overflows++;
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [MAX_CFG_BITS-1:0] cfg_wdata;

  pdr_in_if  in_ch();
  pdr_out_if out_ch();

  reassembly_scoreboard sb = new();

  int unsigned bytes_sent = 0;
  int unsigned limits_used = 0;
  int unsigned cycles = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  packet_deframer_reassembler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Handshake signals are sampled at the falling edge, half a cycle away from
  // any update, and the transfer they show happens at the next rising edge.
  initial begin
    pdr_result_t got;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.payload_byte   = out_ch.payload_byte;
        got.has_byte       = out_ch.has_byte;
        got.end_of_message = out_ch.end_of_message;
        got.pkt_seq        = out_ch.pkt_seq;
        got.overflow_error = out_ch.overflow_error;
        sb.check_result(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= value;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    sb.note_byte(value);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [LEN_BITS-1:0] len, input logic [7:0] seq_id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    send_byte(len[23:16]);
    send_byte(seq_id);
  endtask

  task automatic send_packet(input logic [LEN_BITS-1:0] len);
    send_header(len, 8'($urandom_range(0, 255)));
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [LEN_BITS-1:0] pick_length(input int unsigned cap);
    if (cap == 0 || $urandom_range(0, 7) == 0) return '0;
    if (cap >= 300 && $urandom_range(0, 59) == 0) return LEN_BITS'($urandom_range(256, 300));
    return LEN_BITS'($urandom_range(1, cap < 24 ? cap : 24));
  endfunction

  // Stops offering items and waits until the block has nothing left in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAX_CFG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = value;
    limits_used++;
  endtask

  initial begin
    int unsigned          target;
    int unsigned          final_limit;
    logic [LEN_BITS-1:0] bad_len;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: empty and short packets with extreme byte values, then random packets.
    send_header(24'd0, 8'h00);
    send_header(24'd1, 8'hFF);
    send_byte(8'hFF);
    send_header(24'd3, 8'h5A);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_header(24'd0, 8'hFF);
    send_header(24'd2, 8'h01);
    send_byte(8'h55);
    send_byte(8'hAA);
    hold_req = 1'b1;
    while (bytes_sent < 180) send_packet(pick_length(MAX_RESET));
    drain();

    // With a zero limit only empty packets get through.
    write_limit('0);
    repeat (8) send_header(24'd0, 8'($urandom_range(0, 255)));
    drain();

    write_limit(MAX_CFG_BITS'(16));
    send_packet(24'd16);
    hold_req = 1'b1;
    target = bytes_sent + 90;
    while (bytes_sent < target) send_packet(pick_length(16));
    drain();

    write_limit(MAX_RESET);
    send_packet(LEN_BITS'($urandom_range(256, 270)));
    target = bytes_sent + 40;
    while (bytes_sent < target) send_packet(pick_length(MAX_RESET));
    drain();

    // Next part: no idling, and it ends with the one overflow of the run.
    gaps_on = 1'b0;
    final_limit = $urandom_range(1, 40);
    write_limit(MAX_CFG_BITS'(final_limit));
    target = bytes_sent + 60;
    while (bytes_sent < target) send_packet(pick_length(final_limit));
    case ($urandom_range(0, 2))
      0:       bad_len = LEN_BITS'(final_limit + 1);
      1:       bad_len = FULL_PACKET_LEN;
      default: bad_len = LEN_BITS'($urandom_range(final_limit + 1, FULL_PACKET_LEN));
    endcase
    send_header(bad_len, 8'($urandom_range(0, 255)));
    repeat (12) send_byte(8'($urandom_range(0, 255)));
    drain();

    // Once halted, a new limit is taken but every byte is still dropped.
    write_limit(MAX_CFG_BITS'($urandom_range(0, MAX_RESET)));
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    drain();

    $display("Fed %0d bytes under %0d limit writes; checked %0d result items.",
             bytes_sent, limits_used, sb.checked);
    $display("Saw %0d messages end and %0d overflow halt.", sb.messages_closed, sb.overflows);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
